[rtl/core/hpsc_pkg.sv]
// Shared types, constants and the CORDIC angle table for the heading controller.
package hpsc_pkg;

  localparam int unsigned AngW = 44;   // CORDIC angle, centidegree/65536
  localparam int unsigned VecW = 44;   // CORDIC vector, |v| < 2^43 after growth

  localparam logic [2:0] RegProp  = 3'd0;
  localparam logic [2:0] RegDeriv = 3'd1;
  localparam logic [2:0] RegLimit = 3'd2;
  localparam logic [2:0] RegThr   = 3'd3;
  localparam logic [2:0] RegNorth = 3'd4;

  // Classified item passed from the front end to the back end.
  typedef struct packed {
    logic               ok;
    logic               restart;
    logic signed [32:0] vy;
    logic signed [32:0] vx;
    logic signed [15:0] yaw;
    logic [23:0]        dt;
  } hpsc_job_t;

  function automatic logic signed [AngW-1:0] atan_lut(input logic [4:0] i);
    logic signed [AngW-1:0] v;
    begin
      case (i)
        5'd0:  v = 44'sd294912000;
        5'd1:  v = 44'sd174096719;
        5'd2:  v = 44'sd91987925;
        5'd3:  v = 44'sd46694507;
        5'd4:  v = 44'sd23437865;
        5'd5:  v = 44'sd11730358;
        5'd6:  v = 44'sd5866610;
        5'd7:  v = 44'sd2933484;
        5'd8:  v = 44'sd1466764;
        5'd9:  v = 44'sd733385;
        5'd10: v = 44'sd366693;
        5'd11: v = 44'sd183346;
        5'd12: v = 44'sd91673;
        5'd13: v = 44'sd45837;
        5'd14: v = 44'sd22918;
        5'd15: v = 44'sd11459;
        5'd16: v = 44'sd5730;
        5'd17: v = 44'sd2865;
        5'd18: v = 44'sd1432;
        5'd19: v = 44'sd716;
        5'd20: v = 44'sd358;
        5'd21: v = 44'sd179;
        5'd22: v = 44'sd90;
        5'd23: v = 44'sd45;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

[rtl/core/hpsc_front.sv]
// Front end: accepts items, checks validity, forms the bearing vector, two-entry queue.
module hpsc_front import hpsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pos_east_i,
  input  logic signed [31:0] pos_north_i,
  input  logic signed [31:0] dest_east_i,
  input  logic signed [31:0] dest_north_i,
  input  logic signed [15:0] current_yaw_i,
  input  logic [23:0]        time_step_i,
  input  logic               has_position_i,
  input  logic               has_attitude_i,
  input  logic               restart_i,
  input  logic               zero_at_north_i,
  output logic               job_valid_o,
  input  logic               job_take_i,
  output hpsc_job_t          job_o
);

  hpsc_job_t  slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       push, pop;
  hpsc_job_t  job_new;
  logic signed [32:0] de, dn;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_take_i;
  assign job_o       = slot_q[rd_q];

  always_comb begin
    de = 33'(dest_east_i) - 33'(pos_east_i);
    dn = 33'(dest_north_i) - 33'(pos_north_i);
    job_new.ok      = has_position_i && has_attitude_i && (time_step_i != '0);
    job_new.restart = restart_i;
    job_new.vy      = zero_at_north_i ? de : dn;
    job_new.vx      = zero_at_north_i ? dn : de;
    job_new.yaw     = current_yaw_i;
    job_new.dt      = time_step_i;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= job_new;
  end

endmodule

[rtl/core/hpsc_back.sv]
// Back end: CORDIC atan2, error wrap, PD law with serial divider, result register.
module hpsc_back import hpsc_pkg::*; #(
  parameter int unsigned CordicSteps = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_take_o,
  input  hpsc_job_t          job_i,
  input  logic [15:0]        prop_gain_i,
  input  logic [15:0]        deriv_gain_i,
  input  logic [14:0]        steer_limit_i,
  input  logic signed [15:0] throttle_level_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               ok_o,
  output logic signed [15:0] desired_yaw_o,
  output logic signed [15:0] heading_error_o,
  output logic signed [15:0] steering_o,
  output logic signed [15:0] throttle_out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_ROT, S_ITER, S_ROUND, S_WRAP, S_MUL, S_SUM, S_DIV, S_FIN, S_OUT
  } state_e;

  localparam int unsigned NumW = 64;

  state_e state_q;
  logic signed [VecW-1:0] x_q, y_q;
  logic signed [AngW-1:0] z_q;
  logic [4:0]  i_q;
  logic signed [15:0] yaw_q, bear_q, err_q, last_q;
  logic        evalid_q;
  logic [23:0] dt_q;
  logic signed [17:0] diff_q;
  logic signed [NumW-1:0] pterm_q;
  logic signed [NumW-1:0] dterm_q;
  logic        neg_q;
  logic [NumW-1:0] rem_q, quo_q;
  logic [32:0] den_q;
  logic [6:0]  bit_q;
  logic        stored_q;

  logic signed [VecW-1:0] xs, ys;
  logic signed [AngW-1:0] zr;
  logic signed [15:0] bclamp;
  logic [AngW-1:0] ax, ay;
  logic signed [17:0] dw;
  logic signed [16:0] derr;
  logic signed [NumW-1:0] num;
  logic [NumW-1:0] rem_sh;
  logic [14:0] qmag;
  logic        load_out;

  assign job_take_o = (state_q == S_IDLE) && (!out_valid_o || !out_stall_i);

  always_comb begin
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    ax = x_q[VecW-1] ? AngW'(-x_q) : AngW'(x_q);
    ay = y_q[VecW-1] ? AngW'(-y_q) : AngW'(y_q);
    zr = (z_q + AngW'(32768)) >>> 16;
    if (zr > AngW'(18000)) bclamp = 16'sd18000;
    else if (zr < -AngW'(18000)) bclamp = -16'sd18000;
    else bclamp = zr[15:0];
    dw = diff_q + 18'sd18000;
    derr = evalid_q ? (17'(err_q) - 17'(last_q)) : '0;
    num = pterm_q + dterm_q;
    rem_sh = {rem_q[NumW-2:0], quo_q[NumW-1]};
    qmag = (quo_q > 64'(steer_limit_i)) ? steer_limit_i : quo_q[14:0];
    load_out = ((state_q == S_IDLE) && job_take_o && job_valid_i && !job_i.ok) ||
               ((state_q == S_OUT) && (!out_valid_o || !out_stall_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
      last_q      <= '0;
      evalid_q    <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (job_take_o && job_valid_i) begin
          if (job_i.restart) begin
            last_q   <= '0;
            evalid_q <= 1'b0;
          end
          x_q   <= VecW'(job_i.vx);
          y_q   <= VecW'(job_i.vy);
          z_q   <= '0;
          yaw_q <= job_i.yaw;
          dt_q  <= job_i.dt;
          i_q   <= '0;
          if (job_i.ok) begin
            state_q <= S_NORM;
          end else begin
            ok_o <= 1'b0;
            desired_yaw_o <= '0;
            heading_error_o <= '0;
            steering_o <= '0;
            throttle_out_o <= '0;
          end
        end
        S_NORM: begin
          if (x_q == '0 && y_q == '0) begin
            bear_q  <= '0;
            diff_q  <= 18'(17'sd0 - 17'(yaw_q));
            state_q <= S_WRAP;
          end else if (ax >= (AngW'(1) << 40) || ay >= (AngW'(1) << 40)) begin
            state_q <= S_ROT;
          end else begin
            x_q <= x_q <<< 1;
            y_q <= y_q <<< 1;
          end
        end
        S_ROT: begin
          if (x_q[VecW-1]) begin
            z_q <= y_q[VecW-1] ? -(AngW'(18000) <<< 16) : (AngW'(18000) <<< 16);
            x_q <= -x_q;
            y_q <= -y_q;
          end
          state_q <= S_ITER;
        end
        S_ITER: begin
          if (!y_q[VecW-1]) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + atan_lut(i_q);
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - atan_lut(i_q);
          end
          if (i_q == 5'(CordicSteps - 1)) state_q <= S_ROUND;
          i_q <= i_q + 5'd1;
        end
        S_ROUND: begin
          bear_q  <= bclamp;
          diff_q  <= 18'(17'(bclamp) - 17'(yaw_q));
          state_q <= S_WRAP;
        end
        S_WRAP: begin
          // diff lies in [-50767,50768]: at most one correction by 36000
          if (dw < 0) diff_q <= diff_q + 18'sd36000;
          else if (dw >= 18'sd36000) diff_q <= diff_q - 18'sd36000;
          else begin
            err_q   <= 16'(dw - 18'sd18000);
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          pterm_q <= NumW'(33'($signed({1'b0, prop_gain_i})) * 33'(err_q));
          dterm_q <= NumW'(34'($signed({1'b0, deriv_gain_i})) * 34'(derr));
          state_q <= S_SUM;
        end
        S_SUM: begin
          pterm_q <= NumW'($signed(pterm_q[32:0])) * NumW'($signed({1'b0, dt_q}));
          dterm_q <= dterm_q * 64'sd1000000;
          state_q <= S_DIV;
          bit_q   <= '0;
          stored_q <= 1'b0;
        end
        S_DIV: begin
          if (!stored_q) begin
            neg_q    <= num[NumW-1];
            quo_q    <= num[NumW-1] ? NumW'(-num) : NumW'(num);
            rem_q    <= '0;
            den_q    <= {1'b0, dt_q, 8'd0};
            stored_q <= 1'b1;
          end else begin
            if (rem_sh >= NumW'(den_q)) begin
              rem_q <= rem_sh - NumW'(den_q);
              quo_q <= {quo_q[NumW-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              quo_q <= {quo_q[NumW-2:0], 1'b0};
            end
            bit_q <= bit_q + 7'd1;
            if (bit_q == 7'(NumW - 1)) state_q <= S_FIN;
          end
        end
        S_FIN: begin
          // round half away: remainder*2 >= den
          if ({rem_q, 1'b0} >= {32'd0, den_q}) quo_q <= quo_q + 64'd1;
          state_q <= S_OUT;
        end
        S_OUT: if (!out_valid_o || !out_stall_i) begin
          ok_o            <= 1'b1;
          desired_yaw_o   <= bear_q;
          heading_error_o <= err_q;
          steering_o      <= neg_q ? -16'(qmag) : 16'(qmag);
          throttle_out_o  <= throttle_level_i;
          last_q          <= err_q;
          evalid_q        <= 1'b1;
          state_q         <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (load_out) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

endmodule

[rtl/core/heading_pd_steering_controller_unit.sv]
// Top level of the PD heading controller: register port, front end and back end.
// The back end works on one item at a time: a take step, vector normalization by
// doubling (as often as the size of the position difference requires), a quadrant
// step, CORDIC_STEPS rotations of one shared CORDIC stage, a rounding step, a wrap
// step with at most one correction, two multiply steps, a restoring divider (load
// plus 64 steps), a rounding step and an output step. Coincident points skip the
// CORDIC; rejected items go to the result register from the take step. A stalled
// output holds the back end in its output step. A two-entry queue lets the front
// accept items while the back end works, and the result register holds a finished
// item until it is taken.
module heading_pd_steering_controller_unit import hpsc_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pos_east_i,
  input  logic signed [31:0] pos_north_i,
  input  logic signed [31:0] dest_east_i,
  input  logic signed [31:0] dest_north_i,
  input  logic signed [15:0] current_yaw_i,
  input  logic [23:0]        time_step_i,
  input  logic               has_position_i,
  input  logic               has_attitude_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               ok_o,
  output logic signed [15:0] desired_yaw_o,
  output logic signed [15:0] heading_error_o,
  output logic signed [15:0] steering_o,
  output logic signed [15:0] throttle_out_o
);

  logic [15:0] prop_q, deriv_q;
  logic [14:0] limit_q;
  logic signed [15:0] thr_q;
  logic        north_q;
  logic        job_valid, job_take;
  hpsc_job_t   job;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q  <= 16'd256;
      deriv_q <= '0;
      limit_q <= 15'd3000;
      thr_q   <= '0;
      north_q <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        RegProp:  prop_q  <= pwdata[15:0];
        RegDeriv: deriv_q <= pwdata[15:0];
        RegLimit: limit_q <= pwdata[14:0];
        RegThr:   thr_q   <= pwdata[15:0];
        RegNorth: north_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      RegProp:  prdata = {16'd0, prop_q};
      RegDeriv: prdata = {16'd0, deriv_q};
      RegLimit: prdata = {17'd0, limit_q};
      RegThr:   prdata = {16'd0, thr_q};
      RegNorth: prdata = {31'd0, north_q};
      default:  prdata = '0;
    endcase
  end

  hpsc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .pos_east_i, .pos_north_i, .dest_east_i, .dest_north_i,
    .current_yaw_i, .time_step_i, .has_position_i, .has_attitude_i, .restart_i,
    .zero_at_north_i(north_q),
    .job_valid_o(job_valid), .job_take_i(job_take), .job_o(job)
  );

  hpsc_back #(.CordicSteps(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_take_o(job_take), .job_i(job),
    .prop_gain_i(prop_q), .deriv_gain_i(deriv_q), .steer_limit_i(limit_q),
    .throttle_level_i(thr_q),
    .out_valid_o, .out_stall_i, .ok_o, .desired_yaw_o, .heading_error_o,
    .steering_o, .throttle_out_o
  );

endmodule
